### design/dae_pkg.sv
// Shared types and constants for the DNS A-record address extractor.
// No dependencies; imported by every module of the block.
package dae_pkg;

   // Fixed section sizes of a DNS response, in bytes
   localparam logic [15:0] HEADER_BYTES = 16'd12;
   localparam logic [15:0] QTAIL_BYTES  = 16'd4;
   localparam logic [15:0] RRFIX_BYTES  = 16'd12;
   localparam logic [15:0] ADDR_BYTES   = 16'd4;

   // Byte offsets inside the fixed part of a resource record
   localparam logic [15:0] RR_TC_FIRST  = 16'd2;
   localparam logic [15:0] RR_TC_LAST   = 16'd5;
   localparam logic [15:0] RR_LEN_FIRST = 16'd10;

   // Type A (1), class IN (1)
   localparam logic [31:0] TYPE_CLASS_A_IN = 32'h0001_0001;

   typedef enum logic [2:0] {
      PH_HEADER = 3'd0,
      PH_QLEN   = 3'd1,
      PH_QLABEL = 3'd2,
      PH_QTAIL  = 3'd3,
      PH_RRFIX  = 3'd4,
      PH_RRDATA = 3'd5,
      PH_DONE   = 3'd6
   } phase_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_beat_type;

   typedef struct packed {
      logic        found;
      logic [31:0] ip_address;
   } rsp_beat_type;

endpackage

### design/dae_in_skid.sv
// Two-entry input buffer for request beats; stall is driven from a register.
// Depends on dae_pkg.
module dae_in_skid (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  dae_pkg::req_beat_type req_beat,
   output logic                  head_valid,
   output dae_pkg::req_beat_type head_beat,
   input  logic                  head_pop
);
   import dae_pkg::*;

   logic         main_valid_ff, main_valid_in;
   logic         skid_valid_ff, skid_valid_in;
   req_beat_type main_beat_ff, main_beat_in;
   req_beat_type skid_beat_ff, skid_beat_in;
   logic         accept;

   assign req_stall  = skid_valid_ff;
   assign accept     = req_valid && !skid_valid_ff;
   assign head_valid = main_valid_ff;
   assign head_beat  = main_beat_ff;

   always_comb begin
      main_valid_in = main_valid_ff;
      main_beat_in  = main_beat_ff;
      skid_valid_in = skid_valid_ff;
      skid_beat_in  = skid_beat_ff;
      if (head_pop || !main_valid_ff) begin
         // main slot frees up: refill from skid first, else from the port
         main_valid_in = skid_valid_ff || accept;
         main_beat_in  = skid_valid_ff ? skid_beat_ff : req_beat;
         skid_valid_in = 1'b0;
      end else if (accept) begin
         skid_valid_in = 1'b1;
         skid_beat_in  = req_beat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_beat_ff <= main_beat_in;
      skid_beat_ff <= skid_beat_in;
   end

endmodule

### design/dae_parser.sv
// Byte-wise DNS response walker: phase, counters and captured record fields.
// Depends on dae_pkg.
module dae_parser (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  head_valid,
   input  dae_pkg::req_beat_type head_beat,
   input  logic                  advance,
   output logic                  head_pop,
   output logic                  result_valid,
   output dae_pkg::rsp_beat_type result_beat
);
   import dae_pkg::*;

   phase_type   phase_ff, phase_in;
   logic [15:0] count_ff, count_in;
   logic [31:0] tc_ff, tc_in;
   logic [15:0] len_ff, len_in;
   logic [31:0] addr_ff, addr_in;
   logic        found_ff, found_in;
   logic [15:0] count_inc;
   logic        match;
   logic [7:0]  b;

   assign b            = head_beat.data_byte;
   assign head_pop     = head_valid && advance;
   assign result_valid = head_pop && head_beat.last_byte;
   assign count_inc    = count_ff + 16'd1;
   assign match        = (tc_ff == TYPE_CLASS_A_IN) && (len_ff == ADDR_BYTES);

   always_comb begin
      phase_in = phase_ff;
      count_in = count_ff;
      tc_in    = tc_ff;
      len_in   = len_ff;
      addr_in  = addr_ff;
      found_in = found_ff;
      unique case (phase_ff)
         PH_HEADER: begin
            count_in = count_inc;
            if (count_inc >= HEADER_BYTES) begin
               count_in = 16'd0;
               phase_in = PH_QLEN;
            end
         end
         PH_QLEN: begin
            count_in = 16'd0;
            if (b == 8'd0) begin
               phase_in = PH_QTAIL;
            end else begin
               len_in   = {8'd0, b};
               phase_in = PH_QLABEL;
            end
         end
         PH_QLABEL: begin
            count_in = count_inc;
            if (count_inc >= len_ff) begin
               count_in = 16'd0;
               phase_in = PH_QLEN;
            end
         end
         PH_QTAIL: begin
            count_in = count_inc;
            if (count_inc >= QTAIL_BYTES) begin
               count_in = 16'd0;
               tc_in    = 32'd0;
               len_in   = 16'd0;
               phase_in = PH_RRFIX;
            end
         end
         PH_RRFIX: begin
            if (count_ff >= RR_TC_FIRST && count_ff <= RR_TC_LAST) begin
               tc_in = {tc_ff[23:0], b};
            end else if (count_ff >= RR_LEN_FIRST) begin
               len_in = {len_ff[7:0], b};
            end
            count_in = count_inc;
            if (count_inc >= RRFIX_BYTES) begin
               count_in = 16'd0;
               addr_in  = 32'd0;
               if (len_in == 16'd0) begin
                  // empty data: next record header follows directly
                  tc_in = 32'd0;
               end else begin
                  phase_in = PH_RRDATA;
               end
            end
         end
         PH_RRDATA: begin
            if (match) begin
               addr_in = {addr_ff[23:0], b};
            end
            count_in = count_inc;
            if (count_inc >= len_ff) begin
               count_in = 16'd0;
               if (match) begin
                  found_in = 1'b1;
                  phase_in = PH_DONE;
               end else begin
                  tc_in    = 32'd0;
                  len_in   = 16'd0;
                  phase_in = PH_RRFIX;
               end
            end
         end
         default: ; // done or unused code: byte ignored
      endcase
   end

   always_comb begin
      result_beat.found      = found_in;
      result_beat.ip_address = found_in ? addr_in : 32'd0;
   end

   always_ff @(posedge clock) begin
      if (reset || result_valid) begin
         phase_ff <= PH_HEADER;
         count_ff <= 16'd0;
         tc_ff    <= 32'd0;
         len_ff   <= 16'd0;
         addr_ff  <= 32'd0;
         found_ff <= 1'b0;
      end else if (head_pop) begin
         phase_ff <= phase_in;
         count_ff <= count_in;
         tc_ff    <= tc_in;
         len_ff   <= len_in;
         addr_ff  <= addr_in;
         found_ff <= found_in;
      end
   end

endmodule

### design/dae_rsp_reg.sv
// Result register for the response channel; frees when the sink takes it.
// Depends on dae_pkg.
module dae_rsp_reg (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  dae_pkg::rsp_beat_type load_beat,
   output logic                  free,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output dae_pkg::rsp_beat_type rsp_beat
);
   import dae_pkg::*;

   logic         valid_ff, valid_in;
   rsp_beat_type beat_ff, beat_in;

   assign free      = !valid_ff || !rsp_stall;
   assign rsp_valid = valid_ff;
   assign rsp_beat  = beat_ff;

   always_comb begin
      valid_in = valid_ff && rsp_stall;
      beat_in  = beat_ff;
      if (load) begin
         valid_in = 1'b1;
         beat_in  = load_beat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      beat_ff <= beat_in;
   end

endmodule

### design/dns_answer_ipv4_extract.sv
// Top level of the DNS response A-record address extractor.
// Depends on dae_pkg, dae_in_skid, dae_parser, dae_rsp_reg.
//
//   channel | direction | handshake             | beat
//   req_    | in        | req_valid / req_stall | data_byte, last_byte
//   rsp_    | out       | rsp_valid / rsp_stall | found, ip_address
//
// One byte is consumed per cycle while the result register is free; the
// parse step is a single pass of short logic between the input buffer
// and the result register, which raises rsp_valid after each last byte.
// Synchronous active-high reset empties both buffers and returns the
// parser to the header phase; the parser also rearms after each last byte.
// req_stall comes from a register (skid slot full); rsp_stall only pauses
// the parser while the result register is still held.
module dns_answer_ipv4_extract (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  dae_pkg::req_beat_type req_beat,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output dae_pkg::rsp_beat_type rsp_beat
);
   import dae_pkg::*;

   logic         head_valid;
   req_beat_type head_beat;
   logic         head_pop;
   logic         out_free;
   logic         result_valid;
   rsp_beat_type result_beat;

   // input buffer: holds up to two beats so stall can be registered
   dae_in_skid u_in_skid (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_beat   (req_beat),
      .head_valid (head_valid),
      .head_beat  (head_beat),
      .head_pop   (head_pop)
   );

   // parser advances only while the result register can take a beat
   dae_parser u_parser (
      .clock        (clock),
      .reset        (reset),
      .head_valid   (head_valid),
      .head_beat    (head_beat),
      .advance      (out_free),
      .head_pop     (head_pop),
      .result_valid (result_valid),
      .result_beat  (result_beat)
   );

   dae_rsp_reg u_rsp_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (result_valid),
      .load_beat (result_beat),
      .free      (out_free),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_beat  (rsp_beat)
   );

endmodule

### sim/dns_answer_ipv4_extract_tb.sv
// Self-checking bench for dns_answer_ipv4_extract: directed datagrams, then random ones.
// Expected answers come from a byte-level parse model kept in this file.
// Depends on dae_pkg and the dns_answer_ipv4_extract RTL.
`timescale 1ns / 100ps

module dns_answer_ipv4_extract_tb;
   import dae_pkg::*;

   localparam int DIRECTED_ROWS  = 19;
   localparam int RANDOM_PHASES  = 4;
   localparam int WATCHDOG_LIMIT = 2000;  // cycles with no beat moving on either side
   localparam int DRAIN_CYCLES   = 8;     // time for a result still in flight to show up
   localparam int GRAM_CAP       = 320;   // longest random datagram, in bytes

   // One byte waiting to go out, with an optional hand-typed answer for its datagram
   typedef struct packed {
      req_beat_type beat;
      logic         typed;
      rsp_beat_type want;
   } wire_byte_type;

   logic          clock     = 1'b0;
   logic          reset     = 1'b1;
   logic          req_valid = 1'b0;
   logic          req_stall;
   req_beat_type  req_beat  = '0;
   logic          rsp_valid;
   logic          rsp_stall = 1'b0;
   rsp_beat_type  rsp_beat;

   wire_byte_type wire_bytes_q[$];   // bytes not yet presented on req_
   wire_byte_type cur_item   = '0;   // byte currently presented on req_
   rsp_beat_type  answer_q[$];       // answers owed by the block, oldest first
   logic [7:0]    gram[$];           // datagram under construction

   int send_idle_pct = 0;
   int stall_pct     = 0;
   int idle_cycles   = 0;
   int mismatches    = 0;

   // Parse model state: one copy, rearmed at reset and after each last byte
   phase_type   p_phase   = PH_HEADER;
   logic [15:0] p_count   = '0;
   logic [31:0] p_tc      = '0;   // type in 31:16, class in 15:0
   logic [15:0] p_len     = '0;   // label length, then record data length
   logic [31:0] p_addr    = '0;
   logic        p_found   = 1'b0;

   dns_answer_ipv4_extract dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_beat  (req_beat),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_beat  (rsp_beat)
   );

   always #1 clock = ~clock;

   // ---------------------------------------------------------------------------
   // Parse model
   // ---------------------------------------------------------------------------
   function automatic void rearm_parse();
      p_phase = PH_HEADER;
      p_count = '0;
      p_tc    = '0;
      p_len   = '0;
      p_addr  = '0;
      p_found = 1'b0;
   endfunction

   // Advance the parse by one datagram byte
   function automatic void parse_dns_byte(input logic [7:0] b);
      logic a_in_hit;
      a_in_hit = (p_tc == TYPE_CLASS_A_IN) && (p_len == ADDR_BYTES);
      case (p_phase)
         PH_HEADER: begin
            p_count = p_count + 16'd1;
            if (p_count >= HEADER_BYTES) begin
               p_count = '0;
               p_phase = PH_QLEN;
            end
         end
         PH_QLEN: begin
            // any nonzero byte is a plain label length, 64..255 included
            p_count = '0;
            if (b == 8'd0) begin
               p_phase = PH_QTAIL;
            end else begin
               p_len   = {8'd0, b};
               p_phase = PH_QLABEL;
            end
         end
         PH_QLABEL: begin
            p_count = p_count + 16'd1;
            if (p_count >= p_len) begin
               p_count = '0;
               p_phase = PH_QLEN;
            end
         end
         PH_QTAIL: begin
            p_count = p_count + 16'd1;
            if (p_count >= QTAIL_BYTES) begin
               p_count = '0;
               p_tc    = '0;
               p_len   = '0;
               p_phase = PH_RRFIX;
            end
         end
         PH_RRFIX: begin
            if (p_count >= RR_TC_FIRST && p_count <= RR_TC_LAST)
               p_tc = {p_tc[23:0], b};
            else if (p_count >= RR_LEN_FIRST)
               p_len = {p_len[7:0], b};
            p_count = p_count + 16'd1;
            if (p_count >= RRFIX_BYTES) begin
               p_count = '0;
               p_addr  = '0;
               // empty record data: next record starts right away
               if (p_len == 16'd0)
                  p_tc = '0;
               else
                  p_phase = PH_RRDATA;
            end
         end
         PH_RRDATA: begin
            if (a_in_hit)
               p_addr = {p_addr[23:0], b};
            p_count = p_count + 16'd1;
            if (p_count >= p_len) begin
               p_count = '0;
               if (a_in_hit) begin
                  p_found = 1'b1;
                  p_phase = PH_DONE;
               end else begin
                  p_tc    = '0;
                  p_len   = '0;
                  p_phase = PH_RRFIX;
               end
            end
         end
         default: ;  // after a match every byte is dropped
      endcase
   endfunction

   // ---------------------------------------------------------------------------
   // Datagram building
   // ---------------------------------------------------------------------------
   function automatic int hex_nibble(input byte c);
      if (c >= "0" && c <= "9")
         return c - "0";
      if (c >= "a" && c <= "f")
         return c - "a" + 10;
      return c - "A" + 10;
   endfunction

   function automatic logic [7:0] hex_byte(input string s, input int at);
      return 8'(hex_nibble(s.getc(at)) * 16 + hex_nibble(s.getc(at + 1)));
   endfunction

   // Append bytes written as hex pairs; "N*HH" stands for N copies of byte HH
   function automatic void load_hex(input string s);
      int         i;
      int         j;
      int         rep;
      logic [7:0] v;
      i = 0;
      while (i < s.len()) begin
         if (s.getc(i) == " ") begin
            i++;
         end else begin
            j = i;
            while (j < s.len() && s.getc(j) != " " && s.getc(j) != "*")
               j++;
            if (j < s.len() && s.getc(j) == "*") begin
               rep = 0;
               for (int k = i; k < j; k++)
                  rep = rep * 10 + (s.getc(k) - "0");
               v = hex_byte(s, j + 1);
               repeat (rep) gram.push_back(v);
               i = j + 3;
            end else begin
               for (int k = i; k < j; k += 2)
                  gram.push_back(hex_byte(s, k));
               i = j;
            end
         end
      end
   endfunction

   // Queue the datagram in gram for sending, last byte flagged
   function automatic void queue_gram(input logic typed, input rsp_beat_type want);
      wire_byte_type item;
      for (int i = 0; i < gram.size(); i++) begin
         item.beat.data_byte = gram[i];
         item.beat.last_byte = (i == gram.size() - 1);
         item.typed          = typed;
         item.want           = want;
         wire_bytes_q.push_back(item);
      end
   endfunction

   // Directed datagrams. q0 is a header plus an empty question name and its
   // type/class; a_rec is the fixed part of a type A, class IN, 4-byte record.
   // Rows with typed = 0 are checked against the parse model.
   function automatic void directed_gram(input int row, output string txt,
                                         output logic typed, output rsp_beat_type want);
      string q0;
      string a_rec;
      q0    = "12*00 00 00010001 ";
      a_rec = "c00c 0001 0001 00000e10 0004 ";
      typed = 1'b1;
      want  = '0;
      case (row)
         0:  txt = "ff";                                            // lone header byte
         1:  txt = "12*00";                                         // header only
         2: begin                                                   // all-ones header, qtail, TTL, address
            txt  = "12*ff 00 ffffffff c00c 0001 0001 ffffffff 0004 ffffffff";
            want = {1'b1, 32'hffff_ffff};
         end
         3: begin                                                   // found, address zero
            txt  = {q0, "c00c 0001 0001 00000000 0004 00000000"};
            want = {1'b1, 32'h0000_0000};
         end
         4: begin
            txt  = {"12*00 03616263 00 00010001 ", a_rec, "c0a80001"};
            want = {1'b1, 32'hc0a8_0001};
         end
         5: begin                                                   // label length extremes
            txt  = {"12*00 01ff 40 64*41 ff 255*55 80 128*7f 00 00010001 ", a_rec,
                    "0a000001"};
            want = {1'b1, 32'h0a00_0001};
         end
         6: begin                                                   // alias record first
            txt   = {q0, "c00c 0005 0001 00000e10 0003 616263 ", a_rec, "01020304"};
            typed = 1'b0;
         end
         7: begin                                                   // A record, no data
            txt   = {q0, "c00c 0001 0001 00000e10 0000 ", a_rec, "08080404"};
            typed = 1'b0;
         end
         8: begin                                                   // A record, 5 bytes
            txt   = {q0, "c00c 0001 0001 00000e10 0005 0102030405 ", a_rec, "fefdfcfb"};
            typed = 1'b0;
         end
         9:  txt = {q0, "c00c 0001 0003 00000e10 0004 01020304"};  // wrong class
         10: begin                                                  // odd type/class, long data
            txt   = {q0, "c00c 0101 0101 00000e10 0004 01020304 ",
                     "c00c 0001 0001 00000e10 0104 260*ab ", a_rec, "7f000001"};
            typed = 1'b0;
         end
         11: txt = {q0, a_rec, "c0a8"};                             // cut inside address
         12: txt = "12*00 00 0001";                                 // cut inside qtype/qclass
         13: txt = "12*00 05 6162";                                 // cut inside a label
         14: txt = {q0, "c00c 00"};                                 // cut inside record header
         15: begin                                                  // later bytes dropped
            txt  = {q0, a_rec, "01020304 ", a_rec, "05060708 ffff"};
            want = {1'b1, 32'h0102_0304};
         end
         16: txt = {q0, "c00c 0001 0001 ffffffff ffff 00112233"};  // huge length, cut
         17: begin
            txt   = {q0, "c00c 1001 8001 00000e10 0004 01020304 ", a_rec, "c6336401"};
            typed = 1'b0;
         end
         default: txt = "12*00 00 00010001";                        // no answer section
      endcase
   endfunction

   // Mostly well-formed responses with random content, some cut short, some noise
   function automatic void build_random_gram();
      int          shape;
      int          label_len;
      int          keep;
      logic [15:0] rr_type;
      logic [15:0] rr_class;
      logic [15:0] rr_len;
      gram.delete();
      shape = $urandom_range(99);
      if (shape < 8) begin
         repeat ($urandom_range(1, 40)) gram.push_back(8'($urandom));
      end else begin
         repeat (12) gram.push_back(8'($urandom));
         repeat ($urandom_range(0, 3)) begin
            label_len = ($urandom_range(15) == 0) ? $urandom_range(64, 255)
                                                  : $urandom_range(1, 6);
            gram.push_back(8'(label_len));
            repeat (label_len) gram.push_back(8'($urandom));
         end
         gram.push_back(8'h00);
         repeat (4) gram.push_back(8'($urandom));
         repeat ($urandom_range(0, 3)) begin
            case ($urandom_range(9))
               0, 1, 2, 3, 4, 5: rr_type = 16'd1;
               6:                rr_type = 16'd5;
               7:                rr_type = 16'd28;
               default:          rr_type = 16'($urandom);
            endcase
            rr_class = ($urandom_range(9) < 7) ? 16'd1 : 16'($urandom);
            case ($urandom_range(9))
               0, 1, 2, 3, 4: rr_len = 16'd4;
               5, 6:          rr_len = 16'($urandom_range(0, 8));
               7:             rr_len = {8'($urandom), 8'h04};  // high length byte set
               8:             rr_len = 16'd0;
               default:       rr_len = 16'($urandom);
            endcase
            if ($urandom_range(4) == 0) begin
               gram.push_back(8'($urandom));
               gram.push_back(8'($urandom));
            end else begin
               gram.push_back(8'hc0);
               gram.push_back(8'h0c);
            end
            gram.push_back(rr_type[15:8]);
            gram.push_back(rr_type[7:0]);
            gram.push_back(rr_class[15:8]);
            gram.push_back(rr_class[7:0]);
            repeat (4) gram.push_back(8'($urandom));
            gram.push_back(rr_len[15:8]);
            gram.push_back(rr_len[7:0]);
            repeat ((rr_len > 330) ? 330 : rr_len) gram.push_back(8'($urandom));
         end
         repeat ($urandom_range(0, 2)) gram.push_back(8'($urandom));
      end
      // truncated responses, and anything too long to send whole
      if (gram.size() > GRAM_CAP || (shape >= 8 && shape < 28)) begin
         keep = $urandom_range(1, (gram.size() > GRAM_CAP) ? GRAM_CAP : gram.size());
         while (gram.size() > keep)
            void'(gram.pop_back());
      end
   endfunction

   // ---------------------------------------------------------------------------
   // Checking
   // ---------------------------------------------------------------------------
   task automatic report_mismatch(input string what);
      $display("[%0t] mismatch: %s", $time, what);
      mismatches++;
   endtask

   task automatic wait_drained();
      while (wire_bytes_q.size() != 0 || req_valid || answer_q.size() != 0)
         @(posedge clock);
   endtask

   // ---------------------------------------------------------------------------
   // Request side: present bytes, run the parse model on every accepted beat
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin : byte_sender
      wire_byte_type nxt;
      rsp_beat_type  fresh;
      if (reset) begin
         req_valid <= 1'b0;
         rearm_parse();
      end else begin
         if (req_valid && !req_stall) begin
            parse_dns_byte(cur_item.beat.data_byte);
            if (cur_item.beat.last_byte) begin
               fresh.found      = p_found;
               fresh.ip_address = p_found ? p_addr : 32'h0;
               answer_q.push_back(cur_item.typed ? cur_item.want : fresh);
               rearm_parse();
            end
         end
         // a stalled beat holds; otherwise pick the next byte or go idle
         if (!req_valid || !req_stall) begin
            if (wire_bytes_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               nxt = wire_bytes_q.pop_front();
               cur_item  <= nxt;
               req_beat  <= nxt.beat;
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Result side: random stall, compare every accepted answer beat
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin : answer_check
      rsp_beat_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (answer_q.size() == 0) begin
               report_mismatch($sformatf("answer with none pending: found=%0b ip=%08h",
                                         rsp_beat.found, rsp_beat.ip_address));
            end else begin
               want = answer_q.pop_front();
               if (rsp_beat.found !== want.found)
                  report_mismatch($sformatf("found=%0b, want %0b",
                                            rsp_beat.found, want.found));
               if (rsp_beat.ip_address !== want.ip_address)
                  report_mismatch($sformatf("ip_address=%08h, want %08h",
                                            rsp_beat.ip_address, want.ip_address));
            end
         end
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // Hang detector: nothing moving on either channel for too long
   always @(posedge clock) begin : watchdog
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // ---------------------------------------------------------------------------
   // Run: reset, directed table, then random phases with different idling
   // ---------------------------------------------------------------------------
   initial begin : stimulus
      string        txt;
      logic         typed;
      rsp_beat_type want;
      int           n_gram;
      int           n_byte;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed datagrams go back to back, so rearm after each last byte is hit
      for (int row = 0; row < DIRECTED_ROWS; row++) begin
         directed_gram(row, txt, typed, want);
         gram.delete();
         load_hex(txt);
         queue_gram(typed, want);
      end
      wait_drained();

      // phases: no idling, sender gaps, receiver stalls, both
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         case (ph)
            0:       begin send_idle_pct = 0;  stall_pct = 0;  end
            1:       begin send_idle_pct = 52; stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  stall_pct = 52; end
            default: begin send_idle_pct = 28; stall_pct = 28; end
         endcase
         n_gram = 0;
         n_byte = 0;
         while (n_byte < 115) begin
            build_random_gram();
            n_byte += gram.size();
            n_gram++;
            queue_gram(1'b0, '0);
         end
         wait_drained();
      end

      // let any stray beat show up before the verdict
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (answer_q.size() != 0)
         report_mismatch($sformatf("%0d answers never arrived", answer_q.size()));
      if (mismatches == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
